/* src/cfe_pkg.sv */
// Package for the command frame encoder: byte constants, output segment
// codes, the queue entry type and the FCS-16 byte update.
// No dependencies.
package cfe_pkg;

  // Frame limits of the command protocol
  localparam int MaxParamWords = 16;
  localparam int MaxPayload    = 256;
  localparam int DataLimitInt  = (MaxPayload - 2) > 255 ? 255 : (MaxPayload - 2);
  localparam logic [7:0] DataLimit = 8'(DataLimitInt);

  // Default depth of the queue between front and back
  localparam int QueueDepth = 4;

  // Item kinds
  localparam logic [1:0] OpHeader = 2'd0;
  localparam logic [1:0] OpParam  = 2'd1;
  localparam logic [1:0] OpData   = 2'd2;

  // Wire bytes
  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscXor   = 8'h20;
  localparam logic [15:0] FcsInit  = 16'hFFFF;
  localparam logic [15:0] FcsPoly  = 16'h8408;

  // Output segments, emitted in ascending order
  localparam int NumSegs = 17;
  localparam logic [4:0] SegFlag = 5'd0;
  localparam logic [4:0] SegCode = 5'd1;
  localparam logic [4:0] SegType = 5'd2;
  localparam logic [4:0] SegNp0  = 5'd3;
  localparam logic [4:0] SegNp1  = 5'd4;
  localparam logic [4:0] SegP0   = 5'd5;
  localparam logic [4:0] SegP1   = 5'd6;
  localparam logic [4:0] SegP2   = 5'd7;
  localparam logic [4:0] SegP3   = 5'd8;
  localparam logic [4:0] SegL0   = 5'd9;
  localparam logic [4:0] SegL1   = 5'd10;
  localparam logic [4:0] SegL2   = 5'd11;
  localparam logic [4:0] SegL3   = 5'd12;
  localparam logic [4:0] SegData = 5'd13;
  localparam logic [4:0] SegF0   = 5'd14;
  localparam logic [4:0] SegF1   = 5'd15;
  localparam logic [4:0] SegEnd  = 5'd16;

  typedef logic [NumSegs-1:0] seg_mask_t;

  // One classified item on its way to the back end
  typedef struct packed {
    seg_mask_t   segs;
    logic [7:0]  code;
    logic [4:0]  np;
    logic [7:0]  dl;
    logic [31:0] word;   // parameter word, or data byte in the low bits
  } entry_t;

  function automatic seg_mask_t seg_bit(input logic [4:0] seg);
    return seg_mask_t'(1) << seg;
  endfunction

  // Segments that close the header, last parameter or last data byte: length word or frame close
  function automatic seg_mask_t tail_mask(input logic has_data);
    if (has_data) begin
      return seg_bit(SegL0) | seg_bit(SegL1) | seg_bit(SegL2) | seg_bit(SegL3);
    end
    return seg_bit(SegF0) | seg_bit(SegF1) | seg_bit(SegEnd);
  endfunction

  // Reflected CRC-16 update over one byte
  function automatic logic [15:0] fcs_byte(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] c;
    c = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ FcsPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* src/cfe_if.sv */
// Stream interfaces of the command frame encoder: item input and byte output.
// No dependencies.
interface cfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  cmd_code;
  logic [4:0]  param_count;
  logic [7:0]  data_len;
  logic [31:0] param_word;
  logic [7:0]  data_byte;

  modport source (output valid, op, cmd_code, param_count, data_len, param_word,
                  data_byte, input ready);
  modport sink   (input valid, op, cmd_code, param_count, data_len, param_word,
                  data_byte, output ready);
endinterface

interface cfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, out_byte, run_last, frame_end, input ready);
  modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface

/* src/cfe_front.sv */
// Front end: accepts items, tracks the frame sequence and turns each
// in-sequence item into a queue entry. Depends on cfe_pkg and cfe_in_if.
module cfe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  cfe_in_if.sink            in_i,
  output logic              push_valid_o,
  output cfe_pkg::entry_t   push_entry_o,
  input  logic              push_ready_i
);

  typedef enum logic [1:0] {
    PhIdle,
    PhParams,
    PhData
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  params_left_q, params_left_d;
  logic [7:0]  bytes_left_q, bytes_left_d;

  logic        accept;
  logic [4:0]  np_sat;
  logic [7:0]  dl_sat;
  logic [4:0]  pl_dec;
  logic [7:0]  bl_dec;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && push_ready_i;

  // Clamp header counts to the frame limits
  assign np_sat = (int'(in_i.param_count) > cfe_pkg::MaxParamWords)
                  ? 5'(cfe_pkg::MaxParamWords) : in_i.param_count;
  assign dl_sat = (in_i.data_len > cfe_pkg::DataLimit) ? cfe_pkg::DataLimit : in_i.data_len;
  assign pl_dec = params_left_q - 5'd1;
  assign bl_dec = bytes_left_q - 8'd1;

  // Classify the word and build its segment list
  always_comb begin
    phase_d             = phase_q;
    params_left_d       = params_left_q;
    bytes_left_d        = bytes_left_q;
    push_valid_o        = 1'b0;
    push_entry_o.segs   = '0;
    push_entry_o.code   = in_i.cmd_code;
    push_entry_o.np     = np_sat;
    push_entry_o.dl     = bytes_left_q;
    push_entry_o.word   = in_i.param_word;
    if (in_i.op == cfe_pkg::OpHeader && phase_q == PhIdle) begin
      push_valid_o      = in_i.valid;
      push_entry_o.dl   = dl_sat;
      push_entry_o.segs = cfe_pkg::seg_bit(cfe_pkg::SegFlag) | cfe_pkg::seg_bit(cfe_pkg::SegCode)
                        | cfe_pkg::seg_bit(cfe_pkg::SegType);
      if (np_sat != '0) begin
        push_entry_o.segs = push_entry_o.segs | cfe_pkg::seg_bit(cfe_pkg::SegNp0)
                          | cfe_pkg::seg_bit(cfe_pkg::SegNp1);
      end else begin
        push_entry_o.segs = push_entry_o.segs | cfe_pkg::tail_mask(dl_sat != '0);
      end
      if (accept) begin
        params_left_d = np_sat;
        bytes_left_d  = dl_sat;
        if (np_sat != '0) begin
          phase_d = PhParams;
        end else if (dl_sat != '0) begin
          phase_d = PhData;
        end
      end
    end else if (in_i.op == cfe_pkg::OpParam && phase_q == PhParams) begin
      push_valid_o      = in_i.valid;
      push_entry_o.segs = cfe_pkg::seg_bit(cfe_pkg::SegP0) | cfe_pkg::seg_bit(cfe_pkg::SegP1)
                        | cfe_pkg::seg_bit(cfe_pkg::SegP2) | cfe_pkg::seg_bit(cfe_pkg::SegP3);
      if (pl_dec == '0) begin
        push_entry_o.segs = push_entry_o.segs | cfe_pkg::tail_mask(bytes_left_q != '0);
      end
      if (accept) begin
        params_left_d = pl_dec;
        if (pl_dec == '0) begin
          phase_d = (bytes_left_q != '0) ? PhData : PhIdle;
        end
      end
    end else if (in_i.op == cfe_pkg::OpData && phase_q == PhData) begin
      push_valid_o      = in_i.valid;
      push_entry_o.word = {24'h0, in_i.data_byte};
      push_entry_o.segs = cfe_pkg::seg_bit(cfe_pkg::SegData);
      if (bl_dec == '0) begin
        push_entry_o.segs = push_entry_o.segs | cfe_pkg::tail_mask(1'b0);
      end
      if (accept) begin
        bytes_left_d = bl_dec;
        if (bl_dec == '0) begin
          phase_d = PhIdle;
        end
      end
    end
  end

  // Hold sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      params_left_q <= '0;
      bytes_left_q  <= '0;
    end else begin
      phase_q       <= phase_d;
      params_left_q <= params_left_d;
      bytes_left_q  <= bytes_left_d;
    end
  end

endmodule

/* src/cfe_queue.sv */
// Short queue of classified entries between the front and back ends.
// Depends on cfe_pkg.
module cfe_queue #(
  parameter int Depth = cfe_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  cfe_pkg::entry_t  push_entry_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output cfe_pkg::entry_t  pop_entry_o,
  input  logic             pop_ready_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cfe_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

/* src/cfe_back.sv */
// Back end: walks the segments of each entry, runs the FCS, stuffs flag and
// escape bytes and drives the output register. Depends on cfe_pkg, cfe_out_if.
module cfe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  cfe_pkg::entry_t  pop_entry_i,
  output logic             pop_ready_o,
  cfe_out_if.source        out_o
);

  cfe_pkg::entry_t    cur_q;
  logic               cur_valid_q;
  cfe_pkg::seg_mask_t mask_q, rest;
  logic               esc_q, esc_d;
  logic [15:0]        fcs_q, fcs_d;
  logic               ov_q;
  logic [7:0]         obyte_q, obyte_d;
  logic               olast_q, oend_q;

  logic [4:0]  seg;
  logic [7:0]  val;
  logic [15:0] fcs_out;
  logic        is_flag, is_fcs, needs_esc, take, last, out_free, fire;

  // Lowest pending segment
  always_comb begin
    seg = '0;
    for (int i = cfe_pkg::NumSegs - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        seg = 5'(i);
      end
    end
  end

  assign fcs_out = fcs_q ^ cfe_pkg::FcsInit;

  // Pick the unstuffed byte of the segment
  always_comb begin
    unique case (seg)
      cfe_pkg::SegFlag: val = cfe_pkg::FlagByte;
      cfe_pkg::SegCode: val = cur_q.code;
      cfe_pkg::SegType: val = 8'd1 + {7'd0, cur_q.np != '0} + {6'd0, cur_q.dl != '0, 1'b0};
      cfe_pkg::SegNp0:  val = {3'd0, cur_q.np};
      cfe_pkg::SegNp1:  val = 8'h00;
      cfe_pkg::SegP0:   val = cur_q.word[7:0];
      cfe_pkg::SegP1:   val = cur_q.word[15:8];
      cfe_pkg::SegP2:   val = cur_q.word[23:16];
      cfe_pkg::SegP3:   val = cur_q.word[31:24];
      cfe_pkg::SegL0:   val = cur_q.dl;
      cfe_pkg::SegL1:   val = 8'h00;
      cfe_pkg::SegL2:   val = 8'h00;
      cfe_pkg::SegL3:   val = 8'h00;
      cfe_pkg::SegData: val = cur_q.word[7:0];
      cfe_pkg::SegF0:   val = fcs_out[7:0];
      cfe_pkg::SegF1:   val = fcs_out[15:8];
      cfe_pkg::SegEnd:  val = cfe_pkg::FlagByte;
      default:          val = 8'h00;
    endcase
  end

  assign is_flag   = (seg == cfe_pkg::SegFlag) || (seg == cfe_pkg::SegEnd);
  assign is_fcs    = (seg == cfe_pkg::SegF0) || (seg == cfe_pkg::SegF1);
  assign needs_esc = !is_flag && ((val == cfe_pkg::FlagByte) || (val == cfe_pkg::EscByte));
  assign rest      = mask_q & ~cfe_pkg::seg_bit(seg);
  assign out_free  = !ov_q || out_o.ready;
  assign fire      = out_free && cur_valid_q;

  // Stuff: escape byte first, then the byte with bit 5 flipped
  always_comb begin
    esc_d   = esc_q;
    fcs_d   = fcs_q;
    take    = 1'b1;
    obyte_d = val;
    if (esc_q) begin
      obyte_d = val ^ cfe_pkg::EscXor;
    end else if (needs_esc) begin
      obyte_d = cfe_pkg::EscByte;
      take    = 1'b0;
    end
    if (fire) begin
      esc_d = !esc_q && needs_esc;
      if (!esc_q && !is_flag && !is_fcs) begin
        fcs_d = cfe_pkg::fcs_byte(fcs_q, val);
      end
      if (seg == cfe_pkg::SegEnd) begin
        fcs_d = cfe_pkg::FcsInit;
      end
    end
  end

  assign last        = take && (rest == '0);
  assign pop_ready_o = !cur_valid_q || (fire && last);

  // Load entries, advance segments, drive the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      mask_q      <= '0;
      esc_q       <= 1'b0;
      fcs_q       <= cfe_pkg::FcsInit;
      ov_q        <= 1'b0;
      olast_q     <= 1'b0;
      oend_q      <= 1'b0;
    end else begin
      esc_q <= esc_d;
      fcs_q <= fcs_d;
      if (pop_ready_o) begin
        cur_valid_q <= pop_valid_i;
        mask_q      <= pop_entry_i.segs;
      end else if (fire && take) begin
        mask_q <= rest;
      end
      if (out_free) begin
        ov_q    <= cur_valid_q;
        olast_q <= last;
        oend_q  <= take && (seg == cfe_pkg::SegEnd);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_ready_o) begin
      cur_q <= pop_entry_i;
    end
    if (fire) begin
      obyte_q <= obyte_d;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_byte  = obyte_q;
  assign out_o.run_last  = olast_q;
  assign out_o.frame_end = oend_q;

  // An open escape always sits behind a shown escape byte
  a_esc_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (ov_q && obyte_q == cfe_pkg::EscByte && !olast_q))
    else $error("escape pending without escape byte on output");

  // The closing flag ends the run of its entry
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oend_q) |-> (olast_q && obyte_q == cfe_pkg::FlagByte))
    else $error("closing flag not last byte");

  // A loaded entry always has a segment left
  a_mask_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (mask_q != '0))
    else $error("active entry without segments");

  // The FCS restarts after each closing flag
  a_fcs_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fire && seg == cfe_pkg::SegEnd) |-> (fcs_q == cfe_pkg::FcsInit))
    else $error("FCS not restarted after frame");

endmodule

/* src/command_frame_encoder_fcs16.sv */
// Top level of the command frame encoder with FCS-16 framing.
// Depends on cfe_pkg, cfe_if, cfe_front, cfe_queue and cfe_back.
//
//   Port   Dir  Moves                       Fields
//   in_i   in   one item per word           op, cmd_code, param_count,
//                                           data_len, param_word, data_byte
//   out_o  out  one wire byte per word      out_byte, run_last, frame_end
//
// The back end sends one byte per cycle while out_o is ready; in bytes, a parameter
// word is 4 to 8, a data byte 1 or 2, the close up to 5 more, an empty frame 6 to 9.
// The front end takes an item every cycle while the entry queue has room.
// Reset is asynchronous and active low; the block is ready right after it.
// A stall on out_o holds the output register; the queue fills, then in_i.ready drops.
module command_frame_encoder_fcs16 #(
  parameter int QueueDepth = cfe_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfe_in_if.sink    in_i,
  cfe_out_if.source out_o
);

  logic             push_valid, push_ready, pop_valid, pop_ready;
  cfe_pkg::entry_t  push_entry, pop_entry;

  cfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  cfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  cfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
